// ===== rtl/drtp_pkg.sv =====
// ----------------------------------------------------------------------------
// drtp_pkg
// Shared types, codes and helpers for the decimal rgb triplet parser.
// ----------------------------------------------------------------------------
package drtp_pkg;

  localparam int unsigned CharW     = 8;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned ColorW    = 24;
  localparam int unsigned InDataW   = 16;  // char_code + target flag, byte padded
  localparam int unsigned OutDataW  = 32;  // status + color, byte padded

  localparam logic [CharW-1:0] CharEol   = 8'd0;
  localparam logic [CharW-1:0] CharComma = 8'd44;
  localparam logic [CharW-1:0] CharZero  = 8'd48;
  localparam logic [CharW-1:0] CharNine  = 8'd57;
  localparam logic [CharW-1:0] CharSpace = 8'd32;
  localparam logic [CharW-1:0] CharTab   = 8'd9;
  localparam logic [CharW-1:0] CharCr    = 8'd13;

  localparam logic [2:0]  MinTokenLen = 3'd5;
  localparam logic [1:0]  MaxCommas   = 2'd3;
  localparam logic [1:0]  NeedCommas  = 2'd2;
  localparam logic [1:0]  IdxBlue     = 2'd2;
  localparam logic [1:0]  IdxDone     = 2'd3;
  localparam logic [11:0] MaxComp     = 12'd255;
  localparam logic [3:0]  Radix       = 4'd10;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_TARGET    = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    PH_SKIP_ID    = 4'b0001,
    PH_SKIP_WS    = 4'b0010,
    PH_TOKEN      = 4'b0100,
    PH_AFTER      = 4'b1000
  } phase_t;

  typedef struct packed {
    status_t           status;
    logic [ColorW-1:0] color;
  } result_t;

  function automatic logic is_blank(input logic [CharW-1:0] c);
    return (c == CharSpace) || (c >= CharTab && c <= CharCr);
  endfunction

  function automatic logic is_digit(input logic [CharW-1:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

endpackage

// ===== rtl/decimal_rgb_triplet_parser_core.sv =====
// ----------------------------------------------------------------------------
// decimal_rgb_triplet_parser_core
// Parses one "<id> R,G,B" text line, one character per word, into a status
// and a packed 24-bit color.
// ----------------------------------------------------------------------------
// One character word is taken every clock cycle while s_tvalid is high and the
// input is not held back. Each word goes into an input register and is applied
// to the line state from there. When applied, the end-of-line word (code 0) also
// puts one result word into the output register, from which it is offered on
// the master side. Other characters produce no output. Input is only held back
// while a finished result waits on a stalled master side and the next
// end-of-line word is up.
module decimal_rgb_triplet_parser_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [7:0] char_code, [8] target_already_set, [15:9] zero
  input  logic [drtp_pkg::InDataW-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [1:0] status, [25:2] color_value, [31:26] zero
  output logic [drtp_pkg::OutDataW-1:0] m_tdata
);

  logic                       in_valid;
  logic [drtp_pkg::CharW-1:0] in_char;
  logic                       in_target;
  logic                       eol;
  logic                       out_free;
  logic                       advance;
  drtp_pkg::result_t          result;
  drtp_pkg::result_t          out_data;

  // an end-of-line word needs room in the output register
  assign advance  = in_valid && (!eol || out_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char   <= s_tdata[7:0];
      in_target <= s_tdata[8];
    end
  end

  drtp_line_state u_line (
    .clk                (clk),
    .rst                (rst),
    .step               (advance),
    .char_code          (in_char),
    .target_already_set (in_target),
    .eol                (eol),
    .result             (result)
  );

  drtp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && eol),
    .load_data (result),
    .free      (out_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_data    (out_data)
  );

  assign m_tdata = {6'd0, out_data.color, out_data.status};

endmodule

// ===== rtl/drtp_line_state.sv =====
// ----------------------------------------------------------------------------
// drtp_line_state
// Per-line parse and validation state; one character is applied per step,
// the end-of-line character yields the result and clears the state.
// ----------------------------------------------------------------------------
module drtp_line_state (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [drtp_pkg::CharW-1:0]    char_code,
  input  logic                          target_already_set,
  output logic                          eol,
  output drtp_pkg::result_t             result
);

  typedef struct packed {
    drtp_pkg::phase_t phase;
    logic [2:0]       token_length;
    logic             last_comma;
    logic [1:0]       comma_count;
    logic [1:0]       comp_idx;
    logic [7:0]       acc;
    logic [15:0]      rg;
    logic             failed;
  } line_t;

  localparam line_t LineClear = '{
    phase:        drtp_pkg::PH_SKIP_ID,
    token_length: 3'd0,
    last_comma:   1'b1,
    comma_count:  2'd0,
    comp_idx:     2'd0,
    acc:          8'd0,
    rg:           16'd0,
    failed:       1'b0
  };

  line_t line_q;
  line_t line_next;

  // blue in progress completes, an earlier component fails
  function automatic line_t close_token(input line_t s);
    line_t r;
    r = s;
    if (!s.failed && s.comp_idx != drtp_pkg::IdxDone) begin
      if (s.comp_idx == drtp_pkg::IdxBlue) begin
        r.comp_idx = drtp_pkg::IdxDone;
      end else begin
        r.failed = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic line_t token_char(input line_t s, input logic [7:0] c);
    line_t       r;
    logic        dig;
    logic [11:0] v;
    r   = s;
    dig = drtp_pkg::is_digit(c);
    v   = 12'(s.acc) * 12'(drtp_pkg::Radix) + 12'(c - drtp_pkg::CharZero);
    if (s.token_length < drtp_pkg::MinTokenLen) begin
      r.token_length = s.token_length + 3'd1;
    end
    if (c == drtp_pkg::CharComma && !s.last_comma) begin
      r.last_comma = 1'b1;
      if (s.comma_count < drtp_pkg::MaxCommas) begin
        r.comma_count = s.comma_count + 2'd1;
      end
    end else if (dig) begin
      r.last_comma = 1'b0;
    end
    if (!s.failed && s.comp_idx != drtp_pkg::IdxDone) begin
      if (dig) begin
        if (v > drtp_pkg::MaxComp) begin
          r.failed = 1'b1;
        end else begin
          r.acc = v[7:0];
        end
      end else if (s.comp_idx == drtp_pkg::IdxBlue) begin
        r.comp_idx = drtp_pkg::IdxDone;
      end else if (c == drtp_pkg::CharComma) begin
        r.rg       = {s.rg[7:0], s.acc};
        r.acc      = 8'd0;
        r.comp_idx = s.comp_idx + 2'd1;
      end else begin
        r.failed = 1'b1;
      end
    end
    return r;
  endfunction

  line_t fin;

  assign eol = (char_code == drtp_pkg::CharEol);

  // state as seen at end of line
  always_comb begin
    fin = line_q;
    if (line_q.phase == drtp_pkg::PH_TOKEN) begin
      fin = close_token(line_q);
    end else if (line_q.phase != drtp_pkg::PH_AFTER) begin
      fin.failed = 1'b1;
    end
  end

  always_comb begin
    result.status = drtp_pkg::ST_MALFORMED;
    result.color  = '0;
    if (target_already_set) begin
      result.status = drtp_pkg::ST_TARGET;
    end else if (fin.token_length >= drtp_pkg::MinTokenLen &&
                 fin.comma_count == drtp_pkg::NeedCommas &&
                 !fin.last_comma && !fin.failed &&
                 fin.comp_idx == drtp_pkg::IdxDone) begin
      result.status = drtp_pkg::ST_OK;
      result.color  = {fin.rg, fin.acc};
    end
  end

  always_comb begin
    line_next = line_q;
    if (eol) begin
      line_next = LineClear;
    end else begin
      case (line_q.phase)
        drtp_pkg::PH_SKIP_ID: begin
          line_next.phase = drtp_pkg::PH_SKIP_WS;
        end
        drtp_pkg::PH_SKIP_WS: begin
          if (!drtp_pkg::is_blank(char_code)) begin
            line_next       = token_char(line_q, char_code);
            line_next.phase = drtp_pkg::PH_TOKEN;
          end
        end
        drtp_pkg::PH_TOKEN: begin
          if (drtp_pkg::is_blank(char_code)) begin
            line_next       = close_token(line_q);
            line_next.phase = drtp_pkg::PH_AFTER;
          end else begin
            line_next = token_char(line_q, char_code);
          end
        end
        default: begin
          line_next = line_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_q <= LineClear;
    end else if (step) begin
      line_q <= line_next;
    end
  end

endmodule

// ===== rtl/drtp_out_reg.sv =====
// ----------------------------------------------------------------------------
// drtp_out_reg
// Result register on the master side; takes a new result while the old one
// leaves in the same cycle.
// ----------------------------------------------------------------------------
module drtp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  drtp_pkg::result_t load_data,
  output logic              free,
  output logic              m_tvalid,
  input  logic              m_tready,
  output drtp_pkg::result_t m_data
);

  logic              valid;
  drtp_pkg::result_t data;

  assign free     = !valid || m_tready;
  assign m_tvalid = valid;
  assign m_data   = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      data <= load_data;
    end
  end

endmodule

// ===== verif/tb_decimal_rgb_triplet_parser_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_decimal_rgb_triplet_parser_core
// Streams text lines into the rgb triplet parser one character word at a time
// and checks each end-of-line status/color word against an in-bench model.
// ----------------------------------------------------------------------------
module tb_decimal_rgb_triplet_parser_core;

  localparam int unsigned WordTarget = 1150;

  class rgb_line_checker;
    drtp_pkg::phase_t  phase;
    logic [2:0]        tok_len;
    logic              at_sep;       // high until a digit, set again by a comma
    logic [1:0]        commas;
    logic [1:0]        comp_idx;
    logic [7:0]        comp_acc;
    logic [15:0]       red_green;
    logic              failed;
    drtp_pkg::result_t expected_colors[$];
    int unsigned       mismatches;

    function new();
      mismatches = 0;
      start_line();
    endfunction

    function void start_line();
      phase     = drtp_pkg::PH_SKIP_ID;
      tok_len   = '0;
      at_sep    = 1'b1;
      commas    = '0;
      comp_idx  = '0;
      comp_acc  = '0;
      red_green = '0;
      failed    = 1'b0;
    endfunction

    function bit is_ws(logic [7:0] c);
      return (c == drtp_pkg::CharSpace) ||
             (c >= drtp_pkg::CharTab && c <= drtp_pkg::CharCr);
    endfunction

    // a blue component in progress is complete, red or green is not
    function void end_token();
      if (!failed && comp_idx != drtp_pkg::IdxDone) begin
        if (comp_idx == drtp_pkg::IdxBlue) comp_idx = drtp_pkg::IdxDone;
        else failed = 1'b1;
      end
    endfunction

    function void token_char(logic [7:0] c);
      logic        digit;
      int unsigned v;
      digit = (c >= drtp_pkg::CharZero) && (c <= drtp_pkg::CharNine);
      if (tok_len < drtp_pkg::MinTokenLen) tok_len++;
      if (c == drtp_pkg::CharComma && !at_sep) begin
        at_sep = 1'b1;
        if (commas < drtp_pkg::MaxCommas) commas++;
      end else if (digit) begin
        at_sep = 1'b0;
      end
      if (failed || comp_idx == drtp_pkg::IdxDone) return;
      if (digit) begin
        v = 32'(comp_acc) * 32'(drtp_pkg::Radix) + 32'(c - drtp_pkg::CharZero);
        if (v > drtp_pkg::MaxComp) failed = 1'b1;
        else comp_acc = 8'(v);
      end else if (comp_idx == drtp_pkg::IdxBlue) begin
        comp_idx = drtp_pkg::IdxDone;
      end else if (c == drtp_pkg::CharComma) begin
        red_green = {red_green[7:0], comp_acc};
        comp_acc  = '0;
        comp_idx++;
      end else begin
        failed = 1'b1;
      end
    endfunction

    function void take_char(logic [7:0] c, logic tgt);
      drtp_pkg::result_t res;
      if (c == drtp_pkg::CharEol) begin
        if (phase == drtp_pkg::PH_TOKEN) end_token();
        else if (phase != drtp_pkg::PH_AFTER) failed = 1'b1;
        res.color = '0;
        if (tgt) begin
          res.status = drtp_pkg::ST_TARGET;
        end else if (tok_len >= drtp_pkg::MinTokenLen &&
                     commas == drtp_pkg::NeedCommas && !at_sep &&
                     !failed && comp_idx == drtp_pkg::IdxDone) begin
          res.status = drtp_pkg::ST_OK;
          res.color  = {red_green, comp_acc};
        end else begin
          res.status = drtp_pkg::ST_MALFORMED;
        end
        expected_colors.push_back(res);
        start_line();
        return;
      end
      case (phase)
        drtp_pkg::PH_SKIP_ID: phase = drtp_pkg::PH_SKIP_WS;
        drtp_pkg::PH_SKIP_WS: begin
          if (!is_ws(c)) begin
            phase = drtp_pkg::PH_TOKEN;
            token_char(c);
          end
        end
        drtp_pkg::PH_TOKEN: begin
          if (is_ws(c)) begin
            end_token();
            phase = drtp_pkg::PH_AFTER;
          end else begin
            token_char(c);
          end
        end
        default: ;
      endcase
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endfunction

    function void check_color_word(logic [31:0] word);
      drtp_pkg::result_t want;
      if (expected_colors.size() == 0) begin
        report("unexpected word", '0, word);
        return;
      end
      want = expected_colors.pop_front();
      if (word[1:0] !== want.status) report("status", want.status, word[1:0]);
      if (word[25:2] !== want.color) report("color_value", want.color, word[25:2]);
      if (word[31:26] !== '0) report("padding", '0, word[31:26]);
    endfunction

    function int unsigned pending();
      return expected_colors.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  // [7:0] char_code, [8] target_already_set, [15:9] zero
  logic [drtp_pkg::InDataW-1:0]  s_tdata = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  // [1:0] status, [25:2] color_value, [31:26] zero
  logic [drtp_pkg::OutDataW-1:0] m_tdata;

  rgb_line_checker line_chk = new();
  logic [7:0]      line_q[$];
  int unsigned     words_sent = 0;
  bit              no_gaps = 1'b0;
  bit              long_hold_req = 1'b0;

  decimal_rgb_triplet_parser_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb_decimal_rgb_triplet_parser_core: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) line_chk.check_color_word(m_tdata);
  end

  // receiver: mostly ready, short and long stalls, a long hold on each request
  initial begin : receiver
    int unsigned r;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        m_tready = 1'b0;
        repeat (400) @(negedge clk);
        long_hold_req = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          m_tready = 1'b1;
          repeat ($urandom_range(20, 80)) @(negedge clk);
        end else if (r < 85) begin
          m_tready = 1'($urandom_range(0, 1));
          @(negedge clk);
        end else if (r < 96) begin
          m_tready = 1'b0;
          repeat ($urandom_range(1, 4)) @(negedge clk);
        end else begin
          m_tready = 1'b0;
          repeat ($urandom_range(15, 50)) @(negedge clk);
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_blank();
    int unsigned r;
    r = $urandom_range(0, 6);
    if (r < 5) return drtp_pkg::CharTab + 8'(r);
    return drtp_pkg::CharSpace;
  endfunction

  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return drtp_pkg::CharZero + 8'($urandom_range(0, 9));
    if (r == 3) return drtp_pkg::CharComma;
    if (r == 4) return pick_blank();
    return 8'($urandom_range(1, 255));
  endfunction

  // any nonzero character that does not end the token
  function automatic logic [7:0] pick_solid();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    while (c == drtp_pkg::CharSpace ||
           (c >= drtp_pkg::CharTab && c <= drtp_pkg::CharCr)) c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  task automatic push_number(input int unsigned v);
    if (v >= 100) line_q.push_back(drtp_pkg::CharZero + 8'(v / 100));
    if (v >= 10) line_q.push_back(drtp_pkg::CharZero + 8'((v / 10) % 10));
    line_q.push_back(drtp_pkg::CharZero + 8'(v % 10));
  endtask

  task automatic push_component();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return;                     // empty component
    if (r == 1) push_number($urandom_range(256, 999));
    else if (r == 2) begin
      line_q.push_back(drtp_pkg::CharZero);
      push_number($urandom_range(0, 255));
    end else if (r == 3) push_number(255);
    else if (r == 4) push_number(0);
    else push_number($urandom_range(0, 255));
  endtask

  task automatic build_good_line();
    int unsigned r;
    line_q.push_back(8'($urandom_range(1, 255)));
    repeat ($urandom_range(0, 3)) line_q.push_back(pick_blank());
    push_component();
    line_q.push_back(drtp_pkg::CharComma);
    push_component();
    line_q.push_back(drtp_pkg::CharComma);
    push_component();
    r = $urandom_range(0, 9);
    if (r == 6 || r == 7) begin
      repeat ($urandom_range(1, 3)) line_q.push_back(pick_solid());
    end else if (r >= 8) begin
      line_q.push_back(pick_blank());
      repeat ($urandom_range(0, 4)) line_q.push_back(pick_char());
    end
  endtask

  task automatic break_line();
    int unsigned k;
    k = $urandom_range(0, line_q.size() - 1);
    case ($urandom_range(0, 3))
      0: line_q[k] = pick_char();
      1: if (line_q.size() > 1) line_q.delete(k);
      2: begin
        line_q.push_back(drtp_pkg::CharComma);
        line_q.push_back(drtp_pkg::CharZero + 8'($urandom_range(0, 9)));
      end
      default: line_q.insert(k, drtp_pkg::CharComma);
    endcase
  endtask

  task automatic load_text(input string s);
    line_q.delete();
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic send_word(input logic [7:0] c, input logic tgt);
    int unsigned gap;
    s_tdata  = {7'd0, tgt, c};
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    line_chk.take_char(c, tgt);
    words_sent++;
    @(negedge clk);
    gap = no_gaps ? 0 : pick_gap();
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_line(input logic tgt);
    foreach (line_q[i]) send_word(line_q[i], 1'($urandom_range(0, 1)));
    send_word(drtp_pkg::CharEol, tgt);
  endtask

  initial begin : stimulus
    int unsigned r;
    int unsigned waited;
    bit          hold_done;
    hold_done = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed lines
    line_q.delete();
    send_line(1'b1);                  // bare end of line, target set
    send_line(1'b0);                  // bare end of line, empty token
    load_text("#1,2,3x");             // trailing non-digit still accepted
    send_line(1'b0);
    load_text("\377\t1,,2,3 z");      // empty green, text after the token
    send_line(1'b0);
    load_text("a9,9");                // token ends inside green
    send_line(1'b0);

    long_hold_req = 1'b1;
    while (words_sent < WordTarget) begin
      line_q.delete();
      r = $urandom_range(0, 99);
      if (r < 70) begin
        build_good_line();
      end else if (r < 85) begin
        build_good_line();
        break_line();
      end else begin
        repeat ($urandom_range(0, 12)) line_q.push_back(pick_char());
      end
      if (!hold_done && words_sent > 600) begin
        long_hold_req = 1'b1;
        hold_done = 1'b1;
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      send_line(($urandom_range(0, 4) == 0));
    end
    s_tvalid = 1'b0;
    s_tdata  = '0;

    waited = 0;
    while (line_chk.pending() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (line_chk.mismatches == 0 && line_chk.pending() == 0) begin
      $display("tb_decimal_rgb_triplet_parser_core: PASS");
    end else begin
      $display("tb_decimal_rgb_triplet_parser_core: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/drtp_pkg.sv
rtl/drtp_line_state.sv
rtl/drtp_out_reg.sv
rtl/decimal_rgb_triplet_parser_core.sv
verif/tb_decimal_rgb_triplet_parser_core.sv
